// File: rtl/sha1s_pkg.sv
// Shared constants and control types for the SHA-1 stream hasher.
package sha1s_pkg;

	localparam int ROUNDS = 80;

	localparam logic [4:0][31:0] IV = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [2:0] LAST_IDX = 3'd4;

	// sequencer -> round engine
	typedef struct packed {
		logic start;
		logic clear;
	} ctl_t;

	// round engine -> sequencer
	typedef struct packed {
		logic rnd;
		logic early;
		logic done;
	} stat_t;

endpackage

// File: rtl/sha1s_core.sv
// SHA-1 round engine: one round per cycle, chaining value and working variables.
module sha1s_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha1s_pkg::ctl_t      ctl,
	input  logic [31:0]          wv,
	output sha1s_pkg::stat_t     stat,
	output logic [4:0][31:0]     chain
);

	typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} cstate_t;

	cstate_t          st_q;
	logic [6:0]       rnd_q;
	logic [4:0][31:0] h_q;
	logic [31:0]      a_q, b_q, c_q, d_q, e_q;
	logic [31:0]      f, k, t;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sha1s_pkg::K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = sha1s_pkg::K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = sha1s_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sha1s_pkg::K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + wv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= C_IDLE;
			rnd_q <= '0;
			h_q   <= sha1s_pkg::IV;
		end else begin
			unique case (st_q)
				C_IDLE: begin
					if (ctl.clear) begin
						h_q <= sha1s_pkg::IV;
					end else if (ctl.start) begin
						st_q  <= C_ROUND;
						rnd_q <= '0;
					end
				end
				C_ROUND: begin
					if (rnd_q == 7'(sha1s_pkg::ROUNDS - 1)) begin
						st_q  <= C_ADD;
						rnd_q <= '0;
					end else begin
						rnd_q <= rnd_q + 7'd1;
					end
				end
				C_ADD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					st_q   <= C_IDLE;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == C_IDLE && ctl.start) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (st_q == C_ROUND) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign stat.rnd   = (st_q == C_ROUND);
	assign stat.early = (rnd_q < 7'd16);
	assign stat.done  = (st_q == C_ADD);
	assign chain      = h_q;

endmodule

// File: rtl/sha1_stream_hasher.sv
// SHA-1 stream hasher top level: byte packing, padding, schedule and digest output.
//
// Message words enter on msg_valid/msg_stall: data_word carries bytes first byte in
// bits 31..24, byte_count gives how many leading bytes count (values above four act
// as four), is_last closes the message. A word that does not complete a 64-byte block
// is absorbed in the cycle it is taken. A word that completes a block starts a compression
// (80 rounds, one per cycle on the shared round adder, then the chaining add); msg_stall
// stays high meanwhile, and leftover bytes are absorbed afterward. After the last word,
// padding takes one padding state plus one compression, or two of each when fewer than
// nine bytes of the block are free. Then the five digest words h0..h4 are offered on
// dig_valid/dig_stall with word_index 0..4 and last_word on the fifth. While dig_stall
// is high the current word holds; no new message word is taken until the fifth digest
// word has gone, after which the block is ready for the next message. Reset (arst_n
// low) loads the initial chaining value and clears length and position.
module sha1_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        is_last,
	output logic        dig_valid,
	input  logic        dig_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [2:0] {S_IDLE, S_ABSORB, S_PAD, S_PAD2, S_COMP, S_OUT} state_t;

	state_t           state_q, ret_q;
	logic [5:0]       fill_q;
	logic [60:0]      blen_q;
	logic [2:0]       idx_q;
	logic [31:0]      pend_q;
	logic [2:0]       pcnt_q;
	logic             plast_q;
	logic [31:0]      buf_q [16];

	sha1s_pkg::ctl_t  ctl;
	sha1s_pkg::stat_t stat;
	logic [4:0][31:0] chain;

	logic             act, src_last, full, pad_fit;
	logic [31:0]      src_word, wv, mix;
	logic [2:0]       src_cnt, n;
	logic [6:0]       room;
	logic [63:0]      bits;
	logic [63:0]      wen;
	logic [7:0]       wbyte [64];
	logic [5:0]       pos, off;

	always_comb begin
		act = (state_q == S_IDLE && msg_valid) || state_q == S_ABSORB;
		if (state_q == S_IDLE) begin
			src_word = data_word;
			src_cnt  = (byte_count > 3'd4) ? 3'd4 : byte_count;
			src_last = is_last;
		end else begin
			src_word = pend_q;
			src_cnt  = pcnt_q;
			src_last = plast_q;
		end
		room    = 7'd64 - {1'b0, fill_q};
		n       = ({4'd0, src_cnt} > room) ? room[2:0] : src_cnt;
		full    = ({1'b0, fill_q} + {4'd0, n}) == 7'd64;
		pad_fit = (fill_q <= 6'd55);
		bits    = {blen_q, 3'b000};
	end

	always_comb begin
		pos = '0;
		off = '0;
		wen = '0;
		for (int j = 0; j < 16; j++) begin
			for (int b = 0; b < 4; b++) begin
				pos = 6'(4 * j + b);
				off = pos - fill_q;
				wbyte[4*j+b] = 8'h00;
				if (act) begin
					wen[4*j+b]   = (off < {3'd0, n});
					wbyte[4*j+b] = src_word[31 - 8*off[1:0] -: 8];
				end else if (state_q == S_PAD) begin
					if (pos == fill_q) begin
						wen[4*j+b]   = 1'b1;
						wbyte[4*j+b] = sha1s_pkg::PAD_BYTE;
					end else if (pos > fill_q) begin
						wen[4*j+b] = 1'b1;
						if (pad_fit && pos >= 6'd56)
							wbyte[4*j+b] = bits[63 - 8*pos[2:0] -: 8];
					end
				end else if (state_q == S_PAD2) begin
					wen[4*j+b] = 1'b1;
					if (pos >= 6'd56)
						wbyte[4*j+b] = bits[63 - 8*pos[2:0] -: 8];
				end
			end
		end
	end

	assign mix = buf_q[13] ^ buf_q[8] ^ buf_q[2] ^ buf_q[0];
	assign wv  = stat.early ? buf_q[0] : {mix[30:0], mix[31]};

	assign ctl.start = (act && full) || state_q == S_PAD || state_q == S_PAD2;
	assign ctl.clear = state_q == S_OUT && !dig_stall && idx_q == sha1s_pkg::LAST_IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			fill_q  <= '0;
			blen_q  <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q) inside
				S_IDLE, S_ABSORB: begin
					if (act) begin
						fill_q <= fill_q + {3'd0, n};
						blen_q <= blen_q + 61'(n);
						if (full) begin
							state_q <= S_COMP;
							if (src_cnt != n)
								ret_q <= S_ABSORB;
							else if (src_last)
								ret_q <= S_PAD;
							else
								ret_q <= S_IDLE;
						end else if (src_last) begin
							state_q <= S_PAD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_PAD: begin
					fill_q  <= '0;
					state_q <= S_COMP;
					ret_q   <= pad_fit ? S_OUT : S_PAD2;
				end
				S_PAD2: begin
					state_q <= S_COMP;
					ret_q   <= S_OUT;
				end
				S_COMP: begin
					if (stat.done)
						state_q <= ret_q;
				end
				S_OUT: begin
					if (!dig_stall) begin
						if (idx_q == sha1s_pkg::LAST_IDX) begin
							idx_q   <= '0;
							fill_q  <= '0;
							blen_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (act) begin
			pend_q  <= src_word << {n, 3'b000};
			pcnt_q  <= src_cnt - n;
			plast_q <= src_last;
		end
	end

	// block buffer doubles as the message schedule window during rounds
	always_ff @(posedge clk) begin
		if (stat.rnd) begin
			for (int i = 0; i < 15; i++)
				buf_q[i] <= buf_q[i+1];
			buf_q[15] <= wv;
		end else begin
			for (int j = 0; j < 16; j++) begin
				for (int b = 0; b < 4; b++) begin
					if (wen[4*j+b])
						buf_q[j][31 - 8*b -: 8] <= wbyte[4*j+b];
				end
			end
		end
	end

	sha1s_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.wv     (wv),
		.stat   (stat),
		.chain  (chain)
	);

	assign msg_stall   = (state_q != S_IDLE);
	assign dig_valid   = (state_q == S_OUT);
	assign digest_word = chain[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == sha1s_pkg::LAST_IDX);

	a_done_in_comp: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> state_q == S_COMP)
		else $error("compression finished outside wait state");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		stat.rnd |-> msg_stall)
		else $error("message word taken during rounds");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> stat.rnd && state_q == S_COMP)
		else $error("compression did not start");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && !dig_stall && last_word) |=> (fill_q == 6'd0 && blen_q == 61'd0
			&& !dig_valid && !msg_stall))
		else $error("state not cleared after digest");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the SHA-1 stream hasher: directed and random messages.
`timescale 1ns / 1ps

module testbench;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_exp_t;

	typedef struct packed {
		logic         known;
		logic [159:0] digest;
		logic [31:0]  data;
		logic [2:0]   cnt;
		logic         last;
	} stim_row_t;

	localparam int N_DIR = 15;
	localparam logic [159:0] EMPTY_SHA1 = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
	localparam logic [159:0] ABC_SHA1   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

	localparam stim_row_t dir_rows [N_DIR] = '{
		'{1'b1, EMPTY_SHA1, 32'h00000000, 3'd0, 1'b1},
		'{1'b1, ABC_SHA1,   32'h61626300, 3'd3, 1'b1},
		'{1'b0, 160'd0,     32'hffffffff, 3'd4, 1'b0},
		'{1'b0, 160'd0,     32'h00000000, 3'd4, 1'b1},
		'{1'b0, 160'd0,     32'hffffffff, 3'd7, 1'b0},
		'{1'b0, 160'd0,     32'h12345678, 3'd0, 1'b0},
		'{1'b0, 160'd0,     32'h89abcdef, 3'd1, 1'b0},
		'{1'b0, 160'd0,     32'hfedcba98, 3'd2, 1'b0},
		'{1'b0, 160'd0,     32'h76543210, 3'd3, 1'b0},
		'{1'b0, 160'd0,     32'ha5a5a5a5, 3'd5, 1'b0},
		'{1'b0, 160'd0,     32'h5a5a5a5a, 3'd6, 1'b1},
		'{1'b0, 160'd0,     32'hffffffff, 3'd7, 1'b1},
		'{1'b0, 160'd0,     32'hffffffff, 3'd4, 1'b1},
		'{1'b0, 160'd0,     32'h80000000, 3'd1, 1'b1},
		'{1'b1, EMPTY_SHA1, 32'h00000000, 3'd0, 1'b1}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        msg_valid = 1'b0;
	logic        msg_stall;
	logic [31:0] data_word = 32'd0;
	logic [2:0]  byte_count = 3'd0;
	logic        is_last = 1'b0;
	logic        dig_valid;
	logic        dig_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	logic [31:0] hv [5];
	logic [31:0] blk [16];
	logic [5:0]  fill;
	logic [60:0] msg_len;

	digest_exp_t digest_q [$];
	digest_exp_t head;
	int errors = 0;
	int words_sent = 0;
	int gap_pct = 22;
	int stall_pct = 22;

	sha1_stream_hasher dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg_valid(msg_valid),
		.msg_stall(msg_stall),
		.data_word(data_word),
		.byte_count(byte_count),
		.is_last(is_last),
		.dig_valid(dig_valid),
		.dig_stall(dig_stall),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void flag_error(string msg);
		if (errors < 10)
			$display("%0t: %s", $time, msg);
		errors++;
	endfunction

	function automatic logic [31:0] rol(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void sha_restart();
		int i;
		for (i = 0; i < 5; i++)
			hv[i] = sha1s_pkg::IV[i];
		for (i = 0; i < 16; i++)
			blk[i] = 32'd0;
		fill = 6'd0;
		msg_len = 61'd0;
	endfunction

	function automatic void sha_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, t, wv;
		int r;
		w = blk;
		a = hv[0];
		b = hv[1];
		c = hv[2];
		d = hv[3];
		e = hv[4];
		for (r = 0; r < sha1s_pkg::ROUNDS; r++) begin
			if (r < 16) begin
				wv = w[r];
			end else begin
				wv = rol(w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16], 1);
				w[r % 16] = wv;
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = sha1s_pkg::K0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = sha1s_pkg::K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1s_pkg::K2;
			end else begin
				f = b ^ c ^ d;
				k = sha1s_pkg::K3;
			end
			t = rol(a, 5) + f + e + k + wv;
			e = d;
			d = c;
			c = rol(b, 30);
			b = a;
			a = t;
		end
		hv[0] = hv[0] + a;
		hv[1] = hv[1] + b;
		hv[2] = hv[2] + c;
		hv[3] = hv[3] + d;
		hv[4] = hv[4] + e;
	endfunction

	function automatic void sha_absorb(logic [7:0] b);
		int sh;
		sh = 24 - 8 * int'(fill[1:0]);
		blk[fill[5:2]][sh +: 8] = b;
		fill = fill + 6'd1;
		if (fill == 6'd0)
			sha_compress();
	endfunction

	// absorbs one message word; on the final word pads, queues h0..h4, restarts
	function automatic void sha_absorb_word(logic [31:0] data, logic [2:0] cnt, logic last,
			logic known, logic [159:0] digest);
		int n;
		int i;
		logic [63:0] bits;
		digest_exp_t ex;
		n = (cnt > 3'd4) ? 4 : int'(cnt);
		for (i = 0; i < n; i++) begin
			sha_absorb(data[31 - 8 * i -: 8]);
			msg_len = msg_len + 61'd1;
		end
		if (!last)
			return;
		bits = {msg_len, 3'b000};
		sha_absorb(sha1s_pkg::PAD_BYTE);
		while (fill != 6'd56)
			sha_absorb(8'h00);
		for (i = 0; i < 8; i++)
			sha_absorb(bits[63 - 8 * i -: 8]);
		for (i = 0; i < 5; i++) begin
			ex.word = known ? digest[159 - 32 * i -: 32] : hv[i];
			ex.idx = 3'(i);
			ex.last = (ex.idx == sha1s_pkg::LAST_IDX);
			digest_q.push_back(ex);
		end
		sha_restart();
	endfunction

	// called and returns at a falling edge
	task automatic feed_word(logic [31:0] data, logic [2:0] cnt, logic last,
			logic known, logic [159:0] digest);
		while ($urandom_range(99) < gap_pct) begin
			msg_valid <= 1'b0;
			@(negedge clk);
		end
		msg_valid <= 1'b1;
		data_word <= data;
		byte_count <= cnt;
		is_last <= last;
		@(posedge clk);
		while (msg_stall)
			@(posedge clk);
		sha_absorb_word(data, cnt, last, known, digest);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic pause_until_drained();
		msg_valid <= 1'b0;
		do
			@(negedge clk);
		while (digest_q.size() != 0);
	endtask

	always @(negedge clk) begin
		dig_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && dig_valid && !dig_stall) begin
			if (digest_q.size() == 0) begin
				flag_error($sformatf("digest word with none expected: %h idx %0d last %b",
					digest_word, word_index, last_word));
			end else begin
				head = digest_q.pop_front();
				if (digest_word !== head.word || word_index !== head.idx ||
						last_word !== head.last)
					flag_error($sformatf("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
						head.word, head.idx, head.last, digest_word, word_index, last_word));
			end
		end
	end

	initial begin
		int i;
		int w;
		int nwords;
		int msgs;
		logic [2:0] cnt;
		sha_restart();
		msgs = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (i = 0; i < N_DIR; i++) begin
			feed_word(dir_rows[i].data, dir_rows[i].cnt, dir_rows[i].last,
				dir_rows[i].known, dir_rows[i].digest);
			if (i == 1)
				pause_until_drained();
		end

		while (words_sent < 430) begin
			if (msgs >= 15 && msgs < 22) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = 22;
				stall_pct = 22;
			end
			nwords = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 0);
			for (w = 0; w < nwords; w++) begin
				cnt = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4;
				feed_word($urandom, cnt, 1'b0, 1'b0, 160'd0);
			end
			feed_word($urandom, 3'($urandom_range(7)), 1'b1, 1'b0, 160'd0);
			msgs++;
			if (msgs % 6 == 0)
				pause_until_drained();
		end
		msg_valid <= 1'b0;

		while (digest_q.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// File: sha1_stream_hasher.f
rtl/sha1s_pkg.sv
rtl/sha1s_core.sv
rtl/sha1_stream_hasher.sv
verif/testbench.sv
